/* rtl/camera_point_projection_distortion_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the camera point projection block
// Shared wrappers for concurrent assertions with clock and reset.
// ----------------------------------------------------------------------------
`ifndef CAMERA_POINT_PROJECTION_DISTORTION_ASSERT_SVH
`define CAMERA_POINT_PROJECTION_DISTORTION_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CPPD_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("cppd: assertion failed");

// next-cycle implication, disabled during reset
`define CPPD_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("cppd: assertion failed");

`endif

/* rtl/cppd_pkg.sv */
// ----------------------------------------------------------------------------
// cppd_pkg
// Types and constants shared by the projection pipeline and its checker.
// ----------------------------------------------------------------------------
package cppd_pkg;

    // configuration port
    localparam int CFG_AW = 6;
    localparam int CFG_DW = 64;

    // register indexes (byte address is 8 * index)
    localparam logic [2:0] REG_ROT_X = 3'd0;
    localparam logic [2:0] REG_ROT_Y = 3'd1;
    localparam logic [2:0] REG_ROT_Z = 3'd2;
    localparam logic [2:0] REG_TRANS = 3'd3;
    localparam logic [2:0] REG_FOCAL = 3'd4;
    localparam logic [2:0] REG_SKEW  = 3'd5;
    localparam logic [2:0] REG_TANG  = 3'd6;

    // pixel range, signed Q19.4
    localparam logic signed [23:0] PIX_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] PIX_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [23:0] world_x;
        logic signed [23:0] world_y;
        logic signed [23:0] world_z;
        logic signed [23:0] observed_u;
        logic signed [23:0] observed_v;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] predicted_u;
        logic signed [23:0] predicted_v;
        logic signed [23:0] residual_u;
        logic signed [23:0] residual_v;
        logic               behind_camera;
    } out_item_t;

endpackage

/* rtl/camera_point_projection_distortion.sv */
// ----------------------------------------------------------------------------
// camera_point_projection_distortion
// Pinhole projection with radial and tangential lens distortion and residual.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless a stalled output has filled the pipe
// and returns the results in order. Depth is set by the normalizing divider, which
// resolves one quotient bit per stage for x and y in parallel (26 stages),
// and by the chain of multiplies for r2, r4, r6, the radial factor and the
// pixel mapping, each followed by a register. Every stage holds its own valid
// bit; a stalled output holds only the stages behind it that are full, so
// bubbles collapse and the input keeps flowing until the pipe is full.
// Registers sit on a 64-bit APB port at byte address 8 * index: rotation rows
// x, y, z, translation, focal and center, skew and radial, tangential. Write
// them only while no item is in flight.
module camera_point_projection_distortion (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cppd_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cppd_pkg::out_item_t             m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cppd_pkg::CFG_AW-1:0]     paddr,
    input  logic [cppd_pkg::CFG_DW-1:0]     pwdata,
    output logic [cppd_pkg::CFG_DW-1:0]     prdata,
    output logic                            pready
);
    import cppd_pkg::*;

    // quotient bits: two integer, 24 fraction
    localparam int QW       = 26;
    localparam int ST_MUL   = 0;
    localparam int ST_SUM   = 1;
    localparam int ST_ABS   = 2;
    localparam int ST_NORM  = ST_ABS + QW + 1;
    localparam int ST_SQ    = ST_NORM + 1;
    localparam int ST_R2    = ST_NORM + 2;
    localparam int ST_R4    = ST_NORM + 3;
    localparam int ST_R6    = ST_NORM + 4;
    localparam int ST_K3    = ST_NORM + 5;
    localparam int ST_RSUM  = ST_NORM + 6;
    localparam int ST_RCLP  = ST_NORM + 7;
    localparam int ST_XR    = ST_NORM + 8;
    localparam int ST_XRC   = ST_NORM + 9;
    localparam int ST_XD    = ST_NORM + 10;
    localparam int ST_FP    = ST_NORM + 11;
    localparam int ST_ACC   = ST_NORM + 12;
    localparam int ST_PIX   = ST_NORM + 13;
    localparam int ST_OUT   = ST_NORM + 14;
    localparam int NSTG     = ST_OUT + 1;

    localparam logic signed [35:0] RAD_MAX = 36'sh7_FFFF_FFFF;
    localparam logic signed [35:0] RAD_MIN = 36'sh8_0000_0000;

    typedef struct packed {
        logic signed [23:0] obs_u;
        logic signed [23:0] obs_v;
        logic               behind;
    } side_t;

    function automatic logic signed [23:0] sat_pix(input logic signed [36:0] v);
        logic signed [23:0] r;
        if (v > 37'sd8388607) begin
            r = PIX_MAX;
        end else if (v < -37'sd8388608) begin
            r = PIX_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic [62:0] trans_reg;
    logic [63:0] focal_reg, skew_reg;
    logic [31:0] tang_reg;
    logic [2:0]  cfg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_AW-1:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // identity rotation, everything else zero
            rot_x_reg <= 48'h0000_0000_4000;
            rot_y_reg <= 48'h0000_4000_0000;
            rot_z_reg <= 48'h4000_0000_0000;
            trans_reg <= '0;
            focal_reg <= '0;
            skew_reg  <= '0;
            tang_reg  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ROT_X: rot_x_reg <= pwdata[47:0];
                REG_ROT_Y: rot_y_reg <= pwdata[47:0];
                REG_ROT_Z: rot_z_reg <= pwdata[47:0];
                REG_TRANS: trans_reg <= pwdata[62:0];
                REG_FOCAL: focal_reg <= pwdata;
                REG_SKEW:  skew_reg  <= pwdata;
                REG_TANG:  tang_reg  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (cfg_idx)
            REG_ROT_X: prdata = {16'd0, rot_x_reg};
            REG_ROT_Y: prdata = {16'd0, rot_y_reg};
            REG_ROT_Z: prdata = {16'd0, rot_z_reg};
            REG_TRANS: prdata = {1'b0, trans_reg};
            REG_FOCAL: prdata = focal_reg;
            REG_SKEW:  prdata = skew_reg;
            REG_TANG:  prdata = {32'd0, tang_reg};
            default:   prdata = '0;
        endcase
    end

    // register fields
    logic [2:0][47:0]         rot_rows;
    logic signed [15:0]       rot_m [3][3];
    logic signed [20:0]       trn [3];
    logic signed [23:0]       wrd [3];
    logic [15:0]              fx, fy, cx, cy;
    logic signed [15:0]       skew, k1, k2, k3, p1, p2;

    assign rot_rows = {rot_z_reg, rot_y_reg, rot_x_reg};
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rot_m[i][j] = $signed(rot_rows[i][16*j +: 16]);
            end
            trn[i] = $signed(trans_reg[21*i +: 21]);
        end
    end
    assign wrd[0] = s_data.world_x;
    assign wrd[1] = s_data.world_y;
    assign wrd[2] = s_data.world_z;
    assign fx   = focal_reg[15:0];
    assign fy   = focal_reg[31:16];
    assign cx   = focal_reg[47:32];
    assign cy   = focal_reg[63:48];
    assign skew = $signed(skew_reg[15:0]);
    assign k1   = $signed(skew_reg[31:16]);
    assign k2   = $signed(skew_reg[47:32]);
    assign k3   = $signed(skew_reg[63:48]);
    assign p1   = $signed(tang_reg[15:0]);
    assign p2   = $signed(tang_reg[31:16]);

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when empty or when the next one moves
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = ~vld_reg[NSTG-1] | m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = ~vld_reg[k] | en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NSTG-1];

    // observed pixel and behind flag ride along the whole pipe
    side_t side_reg [NSTG];
    logic  cam_behind;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            side_reg[0] <= '{obs_u: s_data.observed_u, obs_v: s_data.observed_v,
                             behind: 1'b0};
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                if (k == ST_ABS) begin
                    side_reg[k] <= '{obs_u: side_reg[k-1].obs_u,
                                     obs_v: side_reg[k-1].obs_v,
                                     behind: cam_behind};
                end else begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Rotation products, then camera coordinates with translation
    // ------------------------------------------------------------------
    logic signed [39:0] mul_reg [3][3];
    logic signed [42:0] cam_reg [3];

    always_ff @(posedge aclk) begin
        if (en[ST_MUL]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    mul_reg[i][j] <= rot_m[i][j] * wrd[j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            for (int i = 0; i < 3; i++) begin
                cam_reg[i] <= 43'(mul_reg[i][0]) + 43'(mul_reg[i][1]) + 43'(mul_reg[i][2])
                            + (43'(trn[i]) <<< 14);
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: magnitudes, 4*depth, wide-angle clamp flags
    // ------------------------------------------------------------------
    logic [42:0] mag_x, mag_y;
    logic [43:0] depth4;

    assign mag_x      = cam_reg[0][42] ? 43'(-cam_reg[0]) : cam_reg[0];
    assign mag_y      = cam_reg[1][42] ? 43'(-cam_reg[1]) : cam_reg[1];
    assign depth4     = {cam_reg[2][41:0], 2'b00};
    assign cam_behind = cam_reg[2][42] | (cam_reg[2] == '0);

    logic [43:0]   dv_rx_reg [0:QW];
    logic [43:0]   dv_ry_reg [0:QW];
    logic [43:0]   dv_d4_reg [0:QW];
    logic [QW-1:0] dv_qx_reg [0:QW];
    logic [QW-1:0] dv_qy_reg [0:QW];
    logic          dv_nx_reg [0:QW];
    logic          dv_ny_reg [0:QW];
    logic          dv_sx_reg [0:QW];
    logic          dv_sy_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (en[ST_ABS]) begin
            dv_rx_reg[0] <= {1'b0, mag_x};
            dv_ry_reg[0] <= {1'b0, mag_y};
            dv_d4_reg[0] <= depth4;
            dv_qx_reg[0] <= '0;
            dv_qy_reg[0] <= '0;
            dv_nx_reg[0] <= cam_reg[0][42];
            dv_ny_reg[0] <= cam_reg[1][42];
            dv_sx_reg[0] <= {1'b0, mag_x} >= depth4;
            dv_sy_reg[0] <= {1'b0, mag_y} >= depth4;
        end
    end

    // restoring division: remainder doubles, compared against 4*depth
    for (genvar j = 1; j <= QW; j++) begin : g_div
        logic [44:0] trial_x, trial_y;
        logic        ge_x, ge_y;

        assign trial_x = {dv_rx_reg[j-1], 1'b0};
        assign trial_y = {dv_ry_reg[j-1], 1'b0};
        assign ge_x    = trial_x >= {1'b0, dv_d4_reg[j-1]};
        assign ge_y    = trial_y >= {1'b0, dv_d4_reg[j-1]};

        always_ff @(posedge aclk) begin
            if (en[ST_ABS+j]) begin
                dv_rx_reg[j] <= ge_x ? 44'(trial_x - {1'b0, dv_d4_reg[j-1]}) : trial_x[43:0];
                dv_ry_reg[j] <= ge_y ? 44'(trial_y - {1'b0, dv_d4_reg[j-1]}) : trial_y[43:0];
                dv_d4_reg[j] <= dv_d4_reg[j-1];
                dv_qx_reg[j] <= {dv_qx_reg[j-1][QW-2:0], ge_x};
                dv_qy_reg[j] <= {dv_qy_reg[j-1][QW-2:0], ge_y};
                dv_nx_reg[j] <= dv_nx_reg[j-1];
                dv_ny_reg[j] <= dv_ny_reg[j-1];
                dv_sx_reg[j] <= dv_sx_reg[j-1];
                dv_sy_reg[j] <= dv_sy_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Normalized coordinates, signed Q.24, carried to the radial multiply
    // ------------------------------------------------------------------
    logic [QW-1:0]      qx_fin, qy_fin;
    logic signed [26:0] nx_reg [ST_NORM:ST_RCLP];
    logic signed [26:0] ny_reg [ST_NORM:ST_RCLP];

    assign qx_fin = dv_sx_reg[QW] ? {QW{1'b1}} : dv_qx_reg[QW];
    assign qy_fin = dv_sy_reg[QW] ? {QW{1'b1}} : dv_qy_reg[QW];

    always_ff @(posedge aclk) begin
        if (en[ST_NORM]) begin
            nx_reg[ST_NORM] <= dv_nx_reg[QW] ? -$signed({1'b0, qx_fin})
                                             : $signed({1'b0, qx_fin});
            ny_reg[ST_NORM] <= dv_ny_reg[QW] ? -$signed({1'b0, qy_fin})
                                             : $signed({1'b0, qy_fin});
        end
        for (int k = ST_NORM + 1; k <= ST_RCLP; k++) begin
            if (en[k]) begin
                nx_reg[k] <= nx_reg[k-1];
                ny_reg[k] <= ny_reg[k-1];
            end
        end
    end

    // squares and cross product
    logic signed [53:0] sq_xx_reg, sq_yy_reg, sq_xy_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_SQ]) begin
            sq_xx_reg <= nx_reg[ST_NORM] * nx_reg[ST_NORM];
            sq_yy_reg <= ny_reg[ST_NORM] * ny_reg[ST_NORM];
            sq_xy_reg <= nx_reg[ST_NORM] * ny_reg[ST_NORM];
        end
    end

    // r2, 2x^2, 2y^2, xy in Q.24
    logic [52:0]        sq_sum;
    logic [28:0]        r2_reg [ST_R2:ST_R4];
    logic [29:0]        xx2_reg, yy2_reg;
    logic signed [29:0] xy_reg;

    assign sq_sum = sq_xx_reg[52:0] + sq_yy_reg[52:0];

    always_ff @(posedge aclk) begin
        if (en[ST_R2]) begin
            r2_reg[ST_R2] <= sq_sum[52:24];
            xx2_reg       <= {sq_xx_reg[52:24], 1'b0};
            yy2_reg       <= {sq_yy_reg[52:24], 1'b0};
            xy_reg        <= $signed(sq_xy_reg[53:24]);
        end
        if (en[ST_R4]) begin
            r2_reg[ST_R4] <= r2_reg[ST_R2];
        end
    end

    // r4, k1 term and tangential products
    logic [57:0]        r2_sq;
    logic [30:0]        tsum_x, tsum_y;
    logic [33:0]        r4_reg;
    logic signed [45:0] a1_reg [ST_R4:ST_K3];
    logic signed [45:0] tu1_reg [ST_R4:ST_XRC];
    logic signed [47:0] tu2_reg [ST_R4:ST_XRC];
    logic signed [47:0] tv1_reg [ST_R4:ST_XRC];
    logic signed [45:0] tv2_reg [ST_R4:ST_XRC];

    assign r2_sq  = r2_reg[ST_R2] * r2_reg[ST_R2];
    assign tsum_x = r2_reg[ST_R2] + xx2_reg;
    assign tsum_y = r2_reg[ST_R2] + yy2_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_R4]) begin
            r4_reg          <= r2_sq[57:24];
            a1_reg[ST_R4]   <= k1 * $signed({1'b0, r2_reg[ST_R2]});
            tu1_reg[ST_R4]  <= p1 * xy_reg;
            tu2_reg[ST_R4]  <= p2 * $signed({1'b0, tsum_x});
            tv1_reg[ST_R4]  <= p1 * $signed({1'b0, tsum_y});
            tv2_reg[ST_R4]  <= p2 * xy_reg;
        end
        for (int k = ST_R4 + 1; k <= ST_K3; k++) begin
            if (en[k]) begin
                a1_reg[k] <= a1_reg[k-1];
            end
        end
        for (int k = ST_R4 + 1; k <= ST_XRC; k++) begin
            if (en[k]) begin
                tu1_reg[k] <= tu1_reg[k-1];
                tu2_reg[k] <= tu2_reg[k-1];
                tv1_reg[k] <= tv1_reg[k-1];
                tv2_reg[k] <= tv2_reg[k-1];
            end
        end
    end

    // r6, k2 term and k3 term
    logic [62:0]        r4r2;
    logic [38:0]        r6_reg;
    logic signed [50:0] a2_reg [ST_R6:ST_K3];
    logic signed [55:0] a3_reg;

    assign r4r2 = r4_reg * r2_reg[ST_R4];

    always_ff @(posedge aclk) begin
        if (en[ST_R6]) begin
            r6_reg         <= r4r2[62:24];
            a2_reg[ST_R6]  <= k2 * $signed({1'b0, r4_reg});
        end
        if (en[ST_K3]) begin
            a2_reg[ST_K3]  <= a2_reg[ST_R6];
            a3_reg         <= k3 * $signed({1'b0, r6_reg});
        end
    end

    // radial factor, then clamp to [-2048, 2048)
    logic signed [45:0] rsum_reg;
    logic signed [35:0] rad_reg;
    logic               rsum_fits;

    assign rsum_fits = rsum_reg[45:35] == {11{rsum_reg[45]}};

    always_ff @(posedge aclk) begin
        if (en[ST_RSUM]) begin
            rsum_reg <= 46'sd16777216 + 46'(a1_reg[ST_K3] >>> 12)
                      + 46'(a2_reg[ST_K3] >>> 12) + 46'(a3_reg >>> 12);
        end
        if (en[ST_RCLP]) begin
            rad_reg <= rsum_fits ? rsum_reg[35:0] : (rsum_reg[45] ? RAD_MIN : RAD_MAX);
        end
    end

    // x * radial, split in two partial products each
    logic signed [44:0] xrh_reg, yrh_reg;
    logic signed [45:0] xrl_reg, yrl_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_XR]) begin
            xrh_reg <= nx_reg[ST_RCLP] * $signed(rad_reg[35:18]);
            xrl_reg <= nx_reg[ST_RCLP] * $signed({1'b0, rad_reg[17:0]});
            yrh_reg <= ny_reg[ST_RCLP] * $signed(rad_reg[35:18]);
            yrl_reg <= ny_reg[ST_RCLP] * $signed({1'b0, rad_reg[17:0]});
        end
    end

    logic signed [63:0] xr_full, yr_full;
    logic signed [39:0] xr_reg, yr_reg;

    assign xr_full = (64'(xrh_reg) <<< 18) + 64'(xrl_reg);
    assign yr_full = (64'(yrh_reg) <<< 18) + 64'(yrl_reg);

    always_ff @(posedge aclk) begin
        if (en[ST_XRC]) begin
            xr_reg <= 40'(xr_full >>> 24);
            yr_reg <= 40'(yr_full >>> 24);
        end
    end

    // distorted coordinates
    logic signed [41:0] xd_reg, yd_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_XD]) begin
            xd_reg <= 42'(xr_reg) + 42'(tu1_reg[ST_XRC] >>> 11)
                    + 42'(tu2_reg[ST_XRC] >>> 12);
            yd_reg <= 42'(yr_reg) + 42'(tv1_reg[ST_XRC] >>> 12)
                    + 42'(tv2_reg[ST_XRC] >>> 11);
        end
    end

    // ------------------------------------------------------------------
    // Pixel mapping: focal and skew products on split halves
    // ------------------------------------------------------------------
    logic signed [16:0] fx_s, fy_s;
    logic signed [37:0] pa_reg, pe_reg;
    logic signed [38:0] pb_reg, pf_reg;
    logic signed [36:0] pc_reg;
    logic signed [37:0] pd_reg;

    assign fx_s = $signed({1'b0, fx});
    assign fy_s = $signed({1'b0, fy});

    always_ff @(posedge aclk) begin
        if (en[ST_FP]) begin
            pa_reg <= fx_s * $signed(xd_reg[41:21]);
            pb_reg <= fx_s * $signed({1'b0, xd_reg[20:0]});
            pc_reg <= skew * $signed(yd_reg[41:21]);
            pd_reg <= skew * $signed({1'b0, yd_reg[20:0]});
            pe_reg <= fy_s * $signed(yd_reg[41:21]);
            pf_reg <= fy_s * $signed({1'b0, yd_reg[20:0]});
        end
    end

    // sums with 32 fraction bits, half an LSB of Q.4 added for rounding
    logic signed [63:0] accu_reg, accv_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_ACC]) begin
            accu_reg <= (64'(pa_reg) <<< 25) + (64'(pc_reg) <<< 21)
                      + (64'(pb_reg) <<< 4) + 64'(pd_reg) + 64'sd134217728;
            accv_reg <= (64'(pe_reg) <<< 25) + (64'(pf_reg) <<< 4) + 64'sd134217728;
        end
    end

    // principal point and saturation
    logic signed [36:0] pu_wide, pv_wide;
    logic signed [23:0] pu_reg, pv_reg;

    assign pu_wide = 37'(accu_reg >>> 28) + 37'($signed({1'b0, cx}));
    assign pv_wide = 37'(accv_reg >>> 28) + 37'($signed({1'b0, cy}));

    always_ff @(posedge aclk) begin
        if (en[ST_PIX]) begin
            pu_reg <= sat_pix(pu_wide);
            pv_reg <= sat_pix(pv_wide);
        end
    end

    // ------------------------------------------------------------------
    // Residuals and output register
    // ------------------------------------------------------------------
    logic signed [24:0] res_u, res_v;
    out_item_t          out_reg;

    assign res_u = 25'(side_reg[ST_PIX].obs_u) - 25'(pu_reg);
    assign res_v = 25'(side_reg[ST_PIX].obs_v) - 25'(pv_reg);

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            if (side_reg[ST_PIX].behind) begin
                out_reg.predicted_u <= PIX_MAX;
                out_reg.predicted_v <= PIX_MAX;
                out_reg.residual_u  <= PIX_MIN;
                out_reg.residual_v  <= PIX_MIN;
            end else begin
                out_reg.predicted_u <= pu_reg;
                out_reg.predicted_v <= pv_reg;
                out_reg.residual_u  <= sat_pix(37'(res_u));
                out_reg.residual_v  <= sat_pix(37'(res_v));
            end
            out_reg.behind_camera <= side_reg[ST_PIX].behind;
        end
    end

    assign m_data = out_reg;

endmodule

/* rtl/cppd_checker.sv */
// ----------------------------------------------------------------------------
// cppd_checker
// Port-level checks for the projection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "camera_point_projection_distortion_assert.svh"

module cppd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input cppd_pkg::in_item_t           s_data,
    input logic                         m_valid,
    input logic                         m_ready,
    input cppd_pkg::out_item_t          m_data,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [cppd_pkg::CFG_AW-1:0]  paddr,
    input logic [cppd_pkg::CFG_DW-1:0]  pwdata,
    input logic [cppd_pkg::CFG_DW-1:0]  prdata,
    input logic                         pready
);
    import cppd_pkg::*;

    logic        in_wait, out_stall, out_free, behind_ok, tang_rd;
    logic        tang_wr_reg;
    logic [31:0] tang_data_reg;
    logic [63:0] tang_expect;

    assign in_wait     = s_valid & ~s_ready;
    assign out_stall   = m_valid & ~m_ready;
    assign out_free    = ~m_valid | m_ready;
    assign behind_ok   = (m_data.predicted_u == PIX_MAX) && (m_data.predicted_v == PIX_MAX)
                      && (m_data.residual_u == PIX_MIN) && (m_data.residual_v == PIX_MIN);
    assign tang_rd     = tang_wr_reg && (paddr[CFG_AW-1:3] == REG_TANG);
    assign tang_expect = {32'd0, tang_data_reg};

    // last completed write to the tangential register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tang_wr_reg <= 1'b0;
        end else begin
            tang_wr_reg <= psel & penable & pwrite & pready
                         & (paddr[CFG_AW-1:3] == REG_TANG);
        end
        tang_data_reg <= pwdata[31:0];
    end

    // a point behind the camera carries the fixed saturated result
    `CPPD_ASSERT_IMP(a_behind_result, aclk, aresetn, m_valid && m_data.behind_camera, behind_ok)
    // a result that is not taken stays put
    `CPPD_ASSERT_NXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(m_data))
    // an offered item that waits stays put
    `CPPD_ASSERT_NXT(a_in_hold, aclk, aresetn, in_wait, s_valid && $stable(s_data))
    // whenever the output can move, the input side is open
    `CPPD_ASSERT_IMP(a_in_open, aclk, aresetn, out_free, s_ready)
    // a write to the tangential register reads back in the next cycle
    `CPPD_ASSERT_IMP(a_tang_readback, aclk, aresetn, tang_rd, prdata == tang_expect)

endmodule

bind camera_point_projection_distortion cppd_checker u_cppd_checker (.*);
